// ===== rtl/core/rpt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the pose-to-transform block.
`timescale 1ns / 1ps
package rpt_pkg;
   localparam int ANGLE_W    = 16;
   localparam int POS_W      = 32;
   localparam int CW         = 36;
   localparam int SC_W       = 32;
   localparam int ANGLE_SH   = 17;
   localparam int ATAN_COUNT = 24;
   localparam int NUM_AXES   = 3;
   localparam int NUM_ROT    = 9;

   localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
   localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } pos_type;

   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] v;
      unique case (idx)
         0:       v = 36'sd843314856;
         1:       v = 36'sd497837829;
         2:       v = 36'sd263043836;
         3:       v = 36'sd133525158;
         4:       v = 36'sd67021686;
         5:       v = 36'sd33543515;
         6:       v = 36'sd16775850;
         7:       v = 36'sd8388437;
         8:       v = 36'sd4194282;
         9:       v = 36'sd2097149;
         10:      v = 36'sd1048575;
         11:      v = 36'sd524287;
         12:      v = 36'sd262143;
         13:      v = 36'sd131071;
         14:      v = 36'sd65535;
         15:      v = 36'sd32767;
         16:      v = 36'sd16383;
         17:      v = 36'sd8191;
         18:      v = 36'sd4095;
         19:      v = 36'sd2047;
         20:      v = 36'sd1023;
         21:      v = 36'sd511;
         22:      v = 36'sd255;
         23:      v = 36'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q.30 product, floored back to Q.30
   function automatic logic signed [SC_W-1:0] mul_q30(input logic signed [SC_W-1:0] a,
                                                       input logic signed [SC_W-1:0] b);
      logic signed [2*SC_W-1:0] p;
      p = a * b;
      return p[SC_W+29:30];
   endfunction
endpackage

// ===== rtl/core/rpt_if.sv =====
// Valid/ready channel interfaces for pose words and transform words.
`timescale 1ns / 1ps
interface rpt_req_if;
   import rpt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] roll_angle;
   logic signed [ANGLE_W-1:0] pitch_angle;
   logic signed [ANGLE_W-1:0] yaw_angle;
   logic signed [POS_W-1:0]   pos_x;
   logic signed [POS_W-1:0]   pos_y;
   logic signed [POS_W-1:0]   pos_z;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
                   input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z,
                 output ready);
endinterface

interface rpt_rsp_if #(parameter int ENTRY_WIDTH = 16);
   import rpt_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] rot_00;
   logic signed [ENTRY_WIDTH-1:0] rot_01;
   logic signed [ENTRY_WIDTH-1:0] rot_02;
   logic signed [ENTRY_WIDTH-1:0] rot_10;
   logic signed [ENTRY_WIDTH-1:0] rot_11;
   logic signed [ENTRY_WIDTH-1:0] rot_12;
   logic signed [ENTRY_WIDTH-1:0] rot_20;
   logic signed [ENTRY_WIDTH-1:0] rot_21;
   logic signed [ENTRY_WIDTH-1:0] rot_22;
   logic signed [POS_W-1:0]       trans_x;
   logic signed [POS_W-1:0]       trans_y;
   logic signed [POS_W-1:0]       trans_z;
   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20,
                   rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20,
                 rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

// ===== rtl/core/rpy_position_to_transform.sv =====
// Top level: pipelined roll/pitch/yaw plus position to 3x4 homogeneous transform.
//
//   channel | dir | word
//   req_if  | in  | roll, pitch, yaw angles (Q2.13) and x, y, z position (Q16.16)
//   rsp_if  | out | nine rotation entries (Q1.ENTRY_FRAC_BITS) and translation
//
// One word per cycle while the output word is taken; the stages are angle fold, one CORDIC
// iteration per stage, sign fix, two multiply stages, round/saturate output register.
// Synchronous reset clears only the valid bits.
// The whole pipeline holds while the output word waits; nothing is dropped or repeated.
`timescale 1ns / 1ps
module rpy_position_to_transform import rpt_pkg::*; #(
   parameter int CORDIC_STAGES   = 16,
   parameter int ENTRY_FRAC_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   rpt_req_if.sink   req_if,
   rpt_rsp_if.source rsp_if
);
   localparam int ENTRY_WIDTH = ENTRY_FRAC_BITS + 2;
   localparam int NUM_ITER    = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
   localparam int RND_SH      = 30 - ENTRY_FRAC_BITS;
   localparam int DEPTH       = NUM_ITER + 5;
   localparam int SW          = SC_W + 2;
   localparam logic signed [SW-1:0] RND_HALF  = (SW'(1) <<< RND_SH) >>> 1;
   localparam logic signed [SW-1:0] ENTRY_ONE = SW'(1) <<< ENTRY_FRAC_BITS;

   logic             adv;
   logic [DEPTH-1:0] vld_ff, vld_in;
   pos_type          pos_ff [DEPTH];

   assign adv          = !vld_ff[DEPTH-1] || rsp_if.ready;
   assign req_if.ready = adv;
   assign rsp_if.valid = vld_ff[DEPTH-1];
   assign vld_in       = {vld_ff[DEPTH-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff[0] <= '{x: req_if.pos_x, y: req_if.pos_y, z: req_if.pos_z};
         for (int k = 1; k < DEPTH; k++) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   // angle fold into +-pi/2
   logic signed [ANGLE_W-1:0] ang [NUM_AXES];
   logic signed [CW-1:0]      zf_in [NUM_AXES];
   logic                      ng_in [NUM_AXES];
   logic signed [CW-1:0]      cx_ff [NUM_ITER+1][NUM_AXES];
   logic signed [CW-1:0]      cy_ff [NUM_ITER+1][NUM_AXES];
   logic signed [CW-1:0]      cz_ff [NUM_ITER+1][NUM_AXES];
   logic                      neg_ff [NUM_ITER+1][NUM_AXES];

   assign ang[0] = req_if.roll_angle;
   assign ang[1] = req_if.pitch_angle;
   assign ang[2] = req_if.yaw_angle;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         zf_in[a] = {{(CW-ANGLE_W-ANGLE_SH){ang[a][ANGLE_W-1]}}, ang[a], {ANGLE_SH{1'b0}}};
         ng_in[a] = 1'b0;
         priority if (zf_in[a] > HALF_PI_Q30) begin
            zf_in[a] = zf_in[a] - PI_Q30;
            ng_in[a] = 1'b1;
         end else if (zf_in[a] < -HALF_PI_Q30) begin
            zf_in[a] = zf_in[a] + PI_Q30;
            ng_in[a] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            cx_ff[0][a]  <= GAIN_Q30;
            cy_ff[0][a]  <= '0;
            cz_ff[0][a]  <= zf_in[a];
            neg_ff[0][a] <= ng_in[a];
         end
      end
   end

   for (genvar g = 1; g <= NUM_ITER; g++) begin : g_iter
      logic signed [CW-1:0] x_in [NUM_AXES];
      logic signed [CW-1:0] y_in [NUM_AXES];
      logic signed [CW-1:0] z_in [NUM_AXES];
      always_comb begin
         for (int a = 0; a < NUM_AXES; a++) begin
            if (!cz_ff[g-1][a][CW-1]) begin
               x_in[a] = cx_ff[g-1][a] - (cy_ff[g-1][a] >>> (g-1));
               y_in[a] = cy_ff[g-1][a] + (cx_ff[g-1][a] >>> (g-1));
               z_in[a] = cz_ff[g-1][a] - atan_q30(g-1);
            end else begin
               x_in[a] = cx_ff[g-1][a] + (cy_ff[g-1][a] >>> (g-1));
               y_in[a] = cy_ff[g-1][a] - (cx_ff[g-1][a] >>> (g-1));
               z_in[a] = cz_ff[g-1][a] + atan_q30(g-1);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               cx_ff[g][a]  <= x_in[a];
               cy_ff[g][a]  <= y_in[a];
               cz_ff[g][a]  <= z_in[a];
               neg_ff[g][a] <= neg_ff[g-1][a];
            end
         end
      end
   end

   // sign fix: sine and cosine per axis
   logic signed [CW-1:0]   sn_in [NUM_AXES];
   logic signed [CW-1:0]   cs_in [NUM_AXES];
   logic signed [SC_W-1:0] sn_ff [NUM_AXES];
   logic signed [SC_W-1:0] cs_ff [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sn_in[a] = neg_ff[NUM_ITER][a] ? -cy_ff[NUM_ITER][a] : cy_ff[NUM_ITER][a];
         cs_in[a] = neg_ff[NUM_ITER][a] ? -cx_ff[NUM_ITER][a] : cx_ff[NUM_ITER][a];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            sn_ff[a] <= sn_in[a][SC_W-1:0];
            cs_ff[a] <= cs_in[a][SC_W-1:0];
         end
      end
   end

   // first products
   logic signed [SC_W-1:0] spsr_ff, spcr_ff, cycp_ff, sycp_ff, cpsr_ff, cpcr_ff;
   logic signed [SC_W-1:0] sycr_ff, sysr_ff, cycr_ff, cysr_ff, sya_ff, cya_ff, nsp_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         spsr_ff <= mul_q30(sn_ff[1], sn_ff[0]);
         spcr_ff <= mul_q30(sn_ff[1], cs_ff[0]);
         cycp_ff <= mul_q30(cs_ff[2], cs_ff[1]);
         sycp_ff <= mul_q30(sn_ff[2], cs_ff[1]);
         cpsr_ff <= mul_q30(cs_ff[1], sn_ff[0]);
         cpcr_ff <= mul_q30(cs_ff[1], cs_ff[0]);
         sycr_ff <= mul_q30(sn_ff[2], cs_ff[0]);
         sysr_ff <= mul_q30(sn_ff[2], sn_ff[0]);
         cycr_ff <= mul_q30(cs_ff[2], cs_ff[0]);
         cysr_ff <= mul_q30(cs_ff[2], sn_ff[0]);
         sya_ff  <= sn_ff[2];
         cya_ff  <= cs_ff[2];
         nsp_ff  <= -sn_ff[1];
      end
   end

   // second products
   logic signed [SC_W-1:0] cyspsr_ff, cyspcr_ff, syspsr_ff, syspcr_ff;
   logic signed [SC_W-1:0] cycp_b_ff, sycp_b_ff, cpsr_b_ff, cpcr_b_ff;
   logic signed [SC_W-1:0] sycr_b_ff, sysr_b_ff, cycr_b_ff, cysr_b_ff, nsp_b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cyspsr_ff <= mul_q30(cya_ff, spsr_ff);
         cyspcr_ff <= mul_q30(cya_ff, spcr_ff);
         syspsr_ff <= mul_q30(sya_ff, spsr_ff);
         syspcr_ff <= mul_q30(sya_ff, spcr_ff);
         cycp_b_ff <= cycp_ff;
         sycp_b_ff <= sycp_ff;
         cpsr_b_ff <= cpsr_ff;
         cpcr_b_ff <= cpcr_ff;
         sycr_b_ff <= sycr_ff;
         sysr_b_ff <= sysr_ff;
         cycr_b_ff <= cycr_ff;
         cysr_b_ff <= cysr_ff;
         nsp_b_ff  <= nsp_ff;
      end
   end

   // round to entry width, clamp to +-1
   function automatic logic [ENTRY_WIDTH-1:0] to_entry(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v + RND_HALF) >>> RND_SH;
      if (r > ENTRY_ONE) r = ENTRY_ONE;
      if (r < -ENTRY_ONE) r = -ENTRY_ONE;
      return r[ENTRY_WIDTH-1:0];
   endfunction

   function automatic logic signed [SW-1:0] ext(input logic signed [SC_W-1:0] v);
      return {{(SW-SC_W){v[SC_W-1]}}, v};
   endfunction

   logic [ENTRY_WIDTH-1:0] rot_in [NUM_ROT];
   logic [ENTRY_WIDTH-1:0] rot_ff [NUM_ROT];

   always_comb begin
      rot_in[0] = to_entry(ext(cycp_b_ff));
      rot_in[1] = to_entry(ext(cyspsr_ff) - ext(sycr_b_ff));
      rot_in[2] = to_entry(ext(cyspcr_ff) + ext(sysr_b_ff));
      rot_in[3] = to_entry(ext(sycp_b_ff));
      rot_in[4] = to_entry(ext(syspsr_ff) + ext(cycr_b_ff));
      rot_in[5] = to_entry(ext(syspcr_ff) - ext(cysr_b_ff));
      rot_in[6] = to_entry(ext(nsp_b_ff));
      rot_in[7] = to_entry(ext(cpsr_b_ff));
      rot_in[8] = to_entry(ext(cpcr_b_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_ROT; k++) begin
            rot_ff[k] <= rot_in[k];
         end
      end
   end

   assign rsp_if.rot_00  = rot_ff[0];
   assign rsp_if.rot_01  = rot_ff[1];
   assign rsp_if.rot_02  = rot_ff[2];
   assign rsp_if.rot_10  = rot_ff[3];
   assign rsp_if.rot_11  = rot_ff[4];
   assign rsp_if.rot_12  = rot_ff[5];
   assign rsp_if.rot_20  = rot_ff[6];
   assign rsp_if.rot_21  = rot_ff[7];
   assign rsp_if.rot_22  = rot_ff[8];
   assign rsp_if.trans_x = pos_ff[DEPTH-1].x;
   assign rsp_if.trans_y = pos_ff[DEPTH-1].y;
   assign rsp_if.trans_z = pos_ff[DEPTH-1].z;
endmodule

// ===== rtl/core/rpt_checker.sv =====
// Port-level checks for the pose-to-transform block, bound to the top level.
`timescale 1ns / 1ps
module rpt_checker import rpt_pkg::*; #(
   parameter int ENTRY_FRAC_BITS = 14
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [ENTRY_FRAC_BITS+1:0] rot_00,
   input logic signed [ENTRY_FRAC_BITS+1:0] rot_20,
   input logic signed [POS_W-1:0]       trans_x
);
   localparam logic signed [ENTRY_FRAC_BITS+1:0] ONE = (ENTRY_FRAC_BITS+2)'(1) <<< ENTRY_FRAC_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rot_00) && $stable(trans_x))
      else $error("stalled response word changed");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output drain");

   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rot_00 <= ONE && rot_00 >= -ONE && rot_20 <= ONE && rot_20 >= -ONE)
      else $error("rotation entry outside +-1");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind rpy_position_to_transform rpt_checker #(.ENTRY_FRAC_BITS(ENTRY_FRAC_BITS)) u_rpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rot_00    (rsp_if.rot_00),
   .rot_20    (rsp_if.rot_20),
   .trans_x   (rsp_if.trans_x)
);
